@@ sv/ubhs_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the bootloader host.
package ubhs_pkg;

	localparam int ImageBytes = 65536;
	localparam int ChunkBytes = 128;

	localparam int AddrW = $clog2(ImageBytes);
	localparam int SizeW = $clog2(ChunkBytes + 1);
	// longest byte sequence: a chunk (size byte, data, checksum) or the erase page list
	localparam int StepSpan = (ChunkBytes + 2 > 19) ? ChunkBytes + 2 : 19;
	localparam int StepW = $clog2(StepSpan);

	localparam logic [7:0] SyncByte = 8'h7F;
	localparam logic [7:0] AckByte = 8'h79;
	localparam logic [7:0] GetIdCmd = 8'h02;
	localparam logic [7:0] GetIdInv = 8'hFD;
	localparam logic [7:0] EraseCmd = 8'h44;
	localparam logic [7:0] EraseInv = 8'hBB;
	localparam logic [7:0] WriteCmd = 8'h31;
	localparam logic [7:0] WriteInv = 8'hCE;
	localparam logic [7:0] GoCmd = 8'h21;
	localparam logic [7:0] GoInv = 8'hDE;

	localparam logic [16:0] ImageLengthReset = 17'd1;
	localparam logic [2:0] EraseLastPageReset = 3'd6;
	localparam logic [31:0] BaseAddressReset = 32'h0800_0000;
	localparam logic [15:0] TimeoutTicksReset = 16'd1000;

	typedef enum logic [1:0] {
		OP_START,
		OP_RX,
		OP_TICK,
		OP_LOAD
	} op_t;

	typedef enum logic [1:0] {
		STAT_BUSY,
		STAT_DONE,
		STAT_ABORT
	} status_t;

	typedef enum logic [1:0] {
		REG_IMAGE_LENGTH,
		REG_ERASE_LAST_PAGE,
		REG_BASE_ADDRESS,
		REG_TIMEOUT_TICKS
	} reg_idx_t;

	typedef enum logic [2:0] {
		BS_CONST,
		BS_ERASE_N,
		BS_FRAME,
		BS_XOR,
		BS_SIZE,
		BS_MEM
	} bsel_t;

	typedef struct packed {
		logic [16:0] image_length;
		logic [2:0]  erase_last_page;
		logic [31:0] base_address;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       store_wr;
		logic       sess_start;
		logic       idle_clr;
		logic       idle_inc;
		logic       abort;
		logic       frame_wa;
		logic       frame_base;
		logic       chunk_start;
		logic       xor_clr;
		logic       emit;
		bsel_t      bsel;
		logic [7:0] cbyte;
		logic [1:0] fidx;
		logic       final_byte;
		logic       push_empty;
		logic       mem_rd;
		status_t    status;
	} dp_cmd_t;

	typedef struct packed {
		op_t              op;
		logic             is_ack;
		logic             tick_expire;
		logic             chunk_none;
		logic             chunk_last;
		logic [SizeW-1:0] chunk_size;
		logic [2:0]       erase_n;
		logic             out_free;
	} dp_stat_t;

endpackage

@@ sv/ubhs_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ubhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/ubhs_regs.sv @@
// Configuration register file behind the APB-style port.
module ubhs_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output ubhs_pkg::cfg_t     cfg
);

	ubhs_pkg::cfg_t     cfg_q;
	ubhs_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx = ubhs_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_length <= ubhs_pkg::ImageLengthReset;
			cfg_q.erase_last_page <= ubhs_pkg::EraseLastPageReset;
			cfg_q.base_address <= ubhs_pkg::BaseAddressReset;
			cfg_q.timeout_ticks <= ubhs_pkg::TimeoutTicksReset;
		end else if (wr_en) begin
			unique case (idx)
				ubhs_pkg::REG_IMAGE_LENGTH: cfg_q.image_length <= pwdata[16:0];
				ubhs_pkg::REG_ERASE_LAST_PAGE: cfg_q.erase_last_page <= pwdata[2:0];
				ubhs_pkg::REG_BASE_ADDRESS: cfg_q.base_address <= pwdata;
				ubhs_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ubhs_pkg::REG_IMAGE_LENGTH: prdata = {15'd0, cfg_q.image_length};
			ubhs_pkg::REG_ERASE_LAST_PAGE: prdata = {29'd0, cfg_q.erase_last_page};
			ubhs_pkg::REG_BASE_ADDRESS: prdata = cfg_q.base_address;
			ubhs_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, cfg_q.timeout_ticks};
			default: prdata = '0;
		endcase
	end

endmodule

@@ sv/ubhs_dp.sv @@
// Datapath: request capture, session counters, image store, byte assembler and result register.
module ubhs_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ubhs_pkg::cfg_t      cfg,
	input  ubhs_pkg::dp_cmd_t   cmd,
	output ubhs_pkg::dp_stat_t  stat,
	input  logic [1:0]          operation,
	input  logic [7:0]          data_byte,
	input  logic [15:0]         load_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          tx_byte_a,
	output logic [7:0]          tx_byte_b,
	output logic [7:0]          tx_byte_c,
	output logic [7:0]          tx_byte_d,
	output logic [2:0]          tx_count,
	output logic                last,
	output logic [1:0]          status
);

	localparam int AddrW = ubhs_pkg::AddrW;
	localparam int SizeW = ubhs_pkg::SizeW;

	// captured request
	ubhs_pkg::op_t    op_q;
	logic [7:0]       data_q;
	logic [15:0]      idx_q;

	// session state
	logic [31:0]      write_address_q;
	logic [16:0]      bytes_sent_q;
	logic [15:0]      idle_ticks_q;

	// byte assembler
	logic [31:0]      frame_q;
	logic [7:0]       xor_q;
	logic [SizeW-1:0] size_q;
	logic [AddrW-1:0] rd_ptr_q;
	logic [7:0]       pack_q [0:2];
	logic [1:0]       pack_cnt_q;

	// result register
	logic             out_valid_q;
	logic [7:0]       out_b0_q;
	logic [7:0]       out_b1_q;
	logic [7:0]       out_b2_q;
	logic [7:0]       out_b3_q;
	logic [2:0]       out_count_q;
	logic             out_last_q;
	ubhs_pkg::status_t out_status_q;

	logic [16:0]      len_eff;
	logic             has_left;
	logic [16:0]      remaining;
	logic             chunk_last;
	logic [SizeW-1:0] chunk_size_d;
	logic             tick_expire;
	logic             store_we;
	logic [7:0]       mem_rdata;
	logic [7:0]       tx_b;
	logic             out_free;
	logic             fire;
	logic             push;

	ubhs_ram #(
		.WIDTH(8),
		.DEPTH(ubhs_pkg::ImageBytes)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(AddrW'(idx_q)),
		.wdata(data_q),
		.re   (cmd.mem_rd),
		.raddr(rd_ptr_q),
		.rdata(mem_rdata)
	);

	assign store_we = cmd.store_wr && (32'(idx_q) < ubhs_pkg::ImageBytes);

	always_comb begin
		if (cfg.image_length == '0) begin
			len_eff = 17'd1;
		end else if (32'(cfg.image_length) > ubhs_pkg::ImageBytes) begin
			len_eff = 17'(ubhs_pkg::ImageBytes);
		end else begin
			len_eff = cfg.image_length;
		end
	end

	assign has_left = len_eff > bytes_sent_q;
	assign remaining = len_eff - bytes_sent_q;
	assign chunk_last = remaining <= 17'(ubhs_pkg::ChunkBytes);
	assign chunk_size_d = chunk_last ? SizeW'(remaining) : SizeW'(ubhs_pkg::ChunkBytes);
	assign tick_expire = ({1'b0, idle_ticks_q} + 17'd1) > {1'b0, cfg.timeout_ticks};

	always_comb begin
		case (cmd.bsel)
			ubhs_pkg::BS_CONST: tx_b = cmd.cbyte;
			ubhs_pkg::BS_ERASE_N: tx_b = {5'd0, cfg.erase_last_page};
			ubhs_pkg::BS_FRAME: tx_b = frame_q[{cmd.fidx, 3'b000} +: 8];
			ubhs_pkg::BS_XOR: tx_b = xor_q;
			ubhs_pkg::BS_SIZE: tx_b = 8'(size_q - SizeW'(1));
			ubhs_pkg::BS_MEM: tx_b = mem_rdata;
			default: tx_b = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign fire = cmd.emit && out_free;
	// a result leaves on the fourth byte, on the final byte, or empty
	assign push = (fire && (cmd.final_byte || pack_cnt_q == 2'd3)) ||
		(cmd.push_empty && out_free);

	always_comb begin
		stat.op = op_q;
		stat.is_ack = data_q == ubhs_pkg::AckByte;
		stat.tick_expire = tick_expire;
		stat.chunk_none = !has_left;
		stat.chunk_last = chunk_last;
		stat.chunk_size = size_q;
		stat.erase_n = cfg.erase_last_page;
		stat.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_address_q <= ubhs_pkg::BaseAddressReset;
			bytes_sent_q <= '0;
			idle_ticks_q <= '0;
			pack_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sess_start || cmd.abort || cmd.frame_base) begin
				write_address_q <= cfg.base_address;
			end else if (cmd.frame_wa) begin
				write_address_q <= write_address_q + 32'(ubhs_pkg::ChunkBytes);
			end

			if (cmd.sess_start || cmd.abort) begin
				bytes_sent_q <= '0;
			end else if (cmd.chunk_start) begin
				bytes_sent_q <= bytes_sent_q + 17'(chunk_size_d);
			end

			if (cmd.sess_start || cmd.abort || cmd.idle_clr) begin
				idle_ticks_q <= '0;
			end else if (cmd.idle_inc) begin
				idle_ticks_q <= idle_ticks_q + 16'd1;
			end

			if (push) begin
				pack_cnt_q <= '0;
			end else if (fire) begin
				pack_cnt_q <= pack_cnt_q + 2'd1;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= ubhs_pkg::op_t'(operation);
			data_q <= data_byte;
			idx_q <= load_index;
		end

		if (cmd.frame_wa) begin
			frame_q <= write_address_q;
		end else if (cmd.frame_base) begin
			frame_q <= cfg.base_address;
		end

		if (cmd.xor_clr) begin
			xor_q <= '0;
		end else if (fire) begin
			xor_q <= xor_q ^ tx_b;
		end

		if (cmd.chunk_start) begin
			size_q <= chunk_size_d;
			rd_ptr_q <= AddrW'(bytes_sent_q);
		end else if (cmd.mem_rd) begin
			rd_ptr_q <= rd_ptr_q + AddrW'(1);
		end

		if (fire && !push) begin
			pack_q[pack_cnt_q] <= tx_b;
		end

		if (push) begin
			out_last_q <= cmd.push_empty || cmd.final_byte;
			out_status_q <= cmd.status;
			if (cmd.push_empty) begin
				out_b0_q <= '0;
				out_b1_q <= '0;
				out_b2_q <= '0;
				out_b3_q <= '0;
				out_count_q <= '0;
			end else begin
				out_b0_q <= (pack_cnt_q == 2'd0) ? tx_b : pack_q[0];
				out_b1_q <= (pack_cnt_q == 2'd1) ? tx_b :
					((pack_cnt_q > 2'd1) ? pack_q[1] : 8'd0);
				out_b2_q <= (pack_cnt_q == 2'd2) ? tx_b :
					((pack_cnt_q == 2'd3) ? pack_q[2] : 8'd0);
				out_b3_q <= (pack_cnt_q == 2'd3) ? tx_b : 8'd0;
				out_count_q <= {1'b0, pack_cnt_q} + 3'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte_a = out_b0_q;
	assign tx_byte_b = out_b1_q;
	assign tx_byte_c = out_b2_q;
	assign tx_byte_d = out_b3_q;
	assign tx_count = out_count_q;
	assign last = out_last_q;
	assign status = out_status_q;

	a_partial_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> out_count_q == 3'd4)
		else $error("non-final result without four bytes");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_count_q == 3'd0 |-> out_last_q)
		else $error("empty result not marked last");

endmodule

@@ sv/ubhs_ctrl.sv @@
// Controller: protocol phase tracking and the byte sequencer driving the datapath.
module ubhs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ubhs_pkg::dp_stat_t  stat,
	output ubhs_pkg::dp_cmd_t   cmd
);

	localparam int StepW = ubhs_pkg::StepW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SYNC,
		PH_GETID,
		PH_ERASE_CMD,
		PH_WRITE_CMD,
		PH_WRITE_ADDR,
		PH_WRITE_DATA,
		PH_GO_CMD,
		PH_GO_ADDR,
		PH_DONE,
		PH_ABORTED
	} phase_t;

	typedef enum logic [2:0] {
		SQ_ONE,
		SQ_TWO,
		SQ_ERASE,
		SQ_FRAME,
		SQ_CHUNK
	} seq_t;

	state_t           state_q, state_d;
	phase_t           phase_q, phase_d;
	logic             active_q, active_d;
	seq_t             seq_q, seq_d;
	logic [StepW-1:0] step_q, step_d;
	logic [7:0]       const_a_q, const_a_d;
	logic [7:0]       const_b_q, const_b_d;
	logic [StepW-1:0] erase_end;
	logic [StepW-1:0] chunk_end;

	assign erase_end = StepW'({stat.erase_n, 1'b0}) + StepW'(4);
	assign chunk_end = StepW'(stat.chunk_size) + StepW'(1);
	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		phase_d = phase_q;
		active_d = active_q;
		seq_d = seq_q;
		step_d = step_q;
		const_a_d = const_a_q;
		const_b_d = const_b_q;

		if (phase_q == PH_DONE) begin
			cmd.status = ubhs_pkg::STAT_DONE;
		end else if (phase_q == PH_ABORTED) begin
			cmd.status = ubhs_pkg::STAT_ABORT;
		end else begin
			cmd.status = ubhs_pkg::STAT_BUSY;
		end

		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end

			ST_DISPATCH: begin
				cmd.xor_clr = 1'b1;
				step_d = '0;
				state_d = ST_EMPTY;
				unique case (stat.op)
					ubhs_pkg::OP_START: begin
						active_d = 1'b1;
						phase_d = PH_SYNC;
						cmd.sess_start = 1'b1;
						seq_d = SQ_ONE;
						const_a_d = ubhs_pkg::SyncByte;
						state_d = ST_EMIT;
					end
					ubhs_pkg::OP_RX: begin
						if (stat.is_ack) begin
							cmd.idle_clr = 1'b1;
							unique case (phase_q)
								PH_SYNC: begin
									seq_d = SQ_TWO;
									const_a_d = ubhs_pkg::GetIdCmd;
									const_b_d = ubhs_pkg::GetIdInv;
									phase_d = PH_GETID;
									state_d = ST_EMIT;
								end
								PH_GETID: begin
									seq_d = SQ_TWO;
									const_a_d = ubhs_pkg::EraseCmd;
									const_b_d = ubhs_pkg::EraseInv;
									phase_d = PH_ERASE_CMD;
									state_d = ST_EMIT;
								end
								PH_ERASE_CMD: begin
									seq_d = SQ_ERASE;
									phase_d = PH_WRITE_CMD;
									state_d = ST_EMIT;
								end
								PH_WRITE_CMD: begin
									seq_d = SQ_TWO;
									const_a_d = ubhs_pkg::WriteCmd;
									const_b_d = ubhs_pkg::WriteInv;
									phase_d = PH_WRITE_ADDR;
									state_d = ST_EMIT;
								end
								PH_WRITE_ADDR: begin
									cmd.frame_wa = 1'b1;
									seq_d = SQ_FRAME;
									phase_d = PH_WRITE_DATA;
									state_d = ST_EMIT;
								end
								PH_WRITE_DATA: begin
									// nothing left after a length change: skip to GO
									if (stat.chunk_none) begin
										phase_d = PH_GO_CMD;
									end else begin
										cmd.chunk_start = 1'b1;
										seq_d = SQ_CHUNK;
										phase_d = stat.chunk_last ? PH_GO_CMD : PH_WRITE_CMD;
										state_d = ST_EMIT;
									end
								end
								PH_GO_CMD: begin
									seq_d = SQ_TWO;
									const_a_d = ubhs_pkg::GoCmd;
									const_b_d = ubhs_pkg::GoInv;
									phase_d = PH_GO_ADDR;
									state_d = ST_EMIT;
								end
								PH_GO_ADDR: begin
									cmd.frame_base = 1'b1;
									seq_d = SQ_FRAME;
									active_d = 1'b0;
									phase_d = PH_DONE;
									state_d = ST_EMIT;
								end
								default: ;
							endcase
						end
					end
					ubhs_pkg::OP_TICK: begin
						if (active_q) begin
							if (stat.tick_expire) begin
								cmd.abort = 1'b1;
								active_d = 1'b0;
								phase_d = PH_ABORTED;
							end else begin
								cmd.idle_inc = 1'b1;
							end
						end
					end
					ubhs_pkg::OP_LOAD: begin
						cmd.store_wr = 1'b1;
					end
					default: ;
				endcase
			end

			ST_EMIT: begin
				cmd.emit = 1'b1;
				cmd.bsel = ubhs_pkg::BS_CONST;
				case (seq_q)
					SQ_ONE: begin
						cmd.cbyte = const_a_q;
						cmd.final_byte = 1'b1;
					end
					SQ_TWO: begin
						cmd.cbyte = (step_q == '0) ? const_a_q : const_b_q;
						cmd.final_byte = step_q != '0;
					end
					SQ_ERASE: begin
						// 00, N, then 00 and page index per page, then checksum
						if (step_q == StepW'(1)) begin
							cmd.bsel = ubhs_pkg::BS_ERASE_N;
						end else if (step_q == erase_end) begin
							cmd.bsel = ubhs_pkg::BS_XOR;
							cmd.final_byte = 1'b1;
						end else if (step_q != '0 && step_q[0]) begin
							cmd.cbyte = 8'((step_q - StepW'(3)) >> 1);
						end
					end
					SQ_FRAME: begin
						if (step_q < StepW'(4)) begin
							cmd.bsel = ubhs_pkg::BS_FRAME;
							cmd.fidx = 2'd3 - step_q[1:0];
						end else begin
							cmd.bsel = ubhs_pkg::BS_XOR;
							cmd.final_byte = 1'b1;
						end
					end
					SQ_CHUNK: begin
						// fetch the next image byte each time one leaves
						cmd.mem_rd = stat.out_free && step_q < StepW'(stat.chunk_size);
						if (step_q == '0) begin
							cmd.bsel = ubhs_pkg::BS_SIZE;
						end else if (step_q == chunk_end) begin
							cmd.bsel = ubhs_pkg::BS_XOR;
							cmd.final_byte = 1'b1;
						end else begin
							cmd.bsel = ubhs_pkg::BS_MEM;
						end
					end
					default: ;
				endcase
				if (stat.out_free) begin
					step_d = step_q + StepW'(1);
					if (cmd.final_byte) begin
						state_d = ST_IDLE;
					end
				end
			end

			ST_EMPTY: begin
				cmd.push_empty = 1'b1;
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
			active_q <= 1'b0;
			seq_q <= SQ_ONE;
			step_q <= '0;
			const_a_q <= '0;
			const_b_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			active_q <= active_d;
			seq_q <= seq_d;
			step_q <= step_d;
			const_a_q <= const_a_d;
			const_b_q <= const_b_d;
		end
	end

	a_active_phase: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> phase_q != PH_IDLE && phase_q != PH_DONE && phase_q != PH_ABORTED)
		else $error("session active outside a running phase");

	a_erase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && seq_q == SQ_ERASE |-> step_q <= erase_end)
		else $error("erase list ran past its checksum");

	a_dispatch_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DISPATCH |=> state_q == ST_EMIT || state_q == ST_EMPTY)
		else $error("dispatch did not start an emission");

endmodule

@@ sv/uart_bootloader_host_sequencer.sv @@
// Top level of the UART bootloader host sequencer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   in       | in_valid / in_stall  | operation, data_byte, load_index
//   out      | out_valid / out_stall| tx_byte_a..d, tx_count, last, status
//   cfg      | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One request at a time: capture, a dispatch state, then one transmit byte per
// cycle from the single byte assembler while out_stall does not hold it (an empty
// result is pushed from its own state); a full 128-byte chunk is 130 bytes.
// arst_n clears control state and loads register reset values; the image store
// is not cleared. in_stall is high from capture until the final result is in the
// output register; out_stall holds that register and halts the assembler.
module uart_bootloader_host_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	input  logic [15:0] load_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte_a,
	output logic [7:0]  tx_byte_b,
	output logic [7:0]  tx_byte_c,
	output logic [7:0]  tx_byte_d,
	output logic [2:0]  tx_count,
	output logic        last,
	output logic [1:0]  status
);

	ubhs_pkg::cfg_t     cfg;
	ubhs_pkg::dp_cmd_t  cmd;
	ubhs_pkg::dp_stat_t stat;

	ubhs_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	ubhs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	ubhs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.operation (operation),
		.data_byte (data_byte),
		.load_index(load_index),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte_a (tx_byte_a),
		.tx_byte_b (tx_byte_b),
		.tx_byte_c (tx_byte_c),
		.tx_byte_d (tx_byte_d),
		.tx_count  (tx_count),
		.last      (last),
		.status    (status)
	);

endmodule
